// ===== src/tbrl_pkg.sv =====
// ============================================================================
// tbrl_pkg
// Shared types and constants of the token bucket rate limiter.
// ============================================================================
package tbrl_pkg;

    // default geometry
    localparam int DEF_ACCOUNT_SLOTS = 256;
    localparam int DEF_NUM_CHANNELS  = 4;

    // field widths
    localparam int SLOT_IN_W = 8;
    localparam int SLOT_IN_N = 2 ** SLOT_IN_W;
    localparam int CHAN_W    = 2;
    localparam int CHAN_MAX  = 2 ** CHAN_W;
    localparam int TIME_W    = 48;
    localparam int CAP_W     = 12;
    localparam int RATE_W    = 32;
    localparam int TOK_W     = 32;
    localparam int FRAC_W    = 20;
    localparam int RETRY_W   = 22;
    localparam int LIVE_W    = 11;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register index layout: bit 0 picks capacity or rate, upper bits the channel
    localparam logic CFG_SEL_CAPACITY = 1'b0;
    localparam logic CFG_SEL_RATE     = 1'b1;

    // opcodes
    localparam logic OP_CONSUME = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    // constants
    localparam logic [CAP_W-1:0]   CAP_RESET  = 12'd8;
    localparam logic [RATE_W-1:0]  RATE_RESET = 32'd4295;
    localparam logic [TOK_W-1:0]   ONE_TOKEN  = 32'h0010_0000;
    localparam logic [RETRY_W-1:0] HOUR_MS    = 22'd3600000;
    localparam logic [LIVE_W-1:0]  LIVE_MAX   = 11'h7FF;
    localparam int                 MS_SCALE   = 1000;

    typedef struct packed {
        logic                 opcode;
        logic [SLOT_IN_W-1:0] account_slot;
        logic [CHAN_W-1:0]    chan_index;
        logic [TIME_W-1:0]    now_us;
    } req_t;

    typedef struct packed {
        logic               allowed;
        logic [RETRY_W-1:0] retry_ms;
        logic [LIVE_W-1:0]  live_buckets;
    } rsp_t;

    typedef struct packed {
        logic [CHAN_MAX-1:0][CAP_W-1:0]  capacity;
        logic [CHAN_MAX-1:0][RATE_W-1:0] rate;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic prep;
        logic mul_lo;
        logic mul_hi;
        logic mul_k;
        logic sum;
        logic write_back;
        logic res_zero;
        logic res_hour;
        logic div_init;
        logic div_step;
        logic div_end;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_query;
        logic was_valid;
        logic has_token;
        logic rate_zero;
        logic div_last;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== src/token_bucket_rate_limiter.sv =====
// throughput: one request at a time; the 23-step restoring divider and three
//   passes through the shared 32x32 multiplier set the query time
// reset: config registers take defaults, then a clearing pass over all
//   ACCOUNT_SLOTS*NUM_CHANNELS table entries (1024 by default) holds req_stall high
// ============================================================================
// token_bucket_rate_limiter
// Table of token buckets, one per account slot and channel, with consume and
// retry-wait query requests.
// ============================================================================
module token_bucket_rate_limiter #(
    parameter int ACCOUNT_SLOTS = tbrl_pkg::DEF_ACCOUNT_SLOTS,
    parameter int NUM_CHANNELS  = tbrl_pkg::DEF_NUM_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  tbrl_pkg::req_t                  req_data,
    // response channel
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output tbrl_pkg::rsp_t                  rsp_data,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tbrl_pkg::*;

    // channel capacities and rates; the user writes them only while idle, the block does not enforce it
    cfg_t         cfg;
    // sequencer commands and datapath status
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // register file for the eight channel settings
    tbrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: takes a request only in its idle state, walks the
    // read / refill steps and then write-back or, where a query needs it, divide,
    // then hands the result to the output register
    tbrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: bucket table memories, shared multiplier, refill adder,
    // bit-serial divider, live count and the response register, which lets
    // the next request start while a result still waits to be taken
    tbrl_dp #(
        .ACCOUNT_SLOTS (ACCOUNT_SLOTS),
        .NUM_CHANNELS  (NUM_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

// ===== src/tbrl_cfg.sv =====
// ============================================================================
// tbrl_cfg
// Per-channel capacity and refill rate registers with write port.
// ============================================================================
module tbrl_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_data,
    output tbrl_pkg::cfg_t                  cfg
);
    import tbrl_pkg::*;

    logic [CAP_W-1:0]  cap_reg  [CHAN_MAX];
    logic [RATE_W-1:0] rate_reg [CHAN_MAX];
    logic [CHAN_W-1:0] wr_chan;
    logic              wr_sel;

    assign wr_chan = cfg_index[CFG_IDX_W-1:1];
    assign wr_sel  = cfg_index[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHAN_MAX; c++)
            begin
                cap_reg[c]  <= CAP_RESET;
                rate_reg[c] <= RATE_RESET;
            end
        end
        else if (cfg_wr_en)
        begin
            if (wr_sel == CFG_SEL_CAPACITY)
                cap_reg[wr_chan] <= cfg_data[CAP_W-1:0];
            else
                rate_reg[wr_chan] <= cfg_data[RATE_W-1:0];
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHAN_MAX; c++)
        begin
            cfg.capacity[c] = cap_reg[c];
            cfg.rate[c]     = rate_reg[c];
        end
    end

endmodule

// ===== src/tbrl_ctrl.sv =====
// ============================================================================
// tbrl_ctrl
// Sequencer: clearing pass, bucket read, refill, write back, retry division.
// ============================================================================
module tbrl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  tbrl_pkg::ctrl_status_t status,
    output tbrl_pkg::ctrl_cmd_t    cmd
);
    import tbrl_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_ELAPSED  = 4'd3;
    localparam logic [3:0] S_MUL_LO   = 4'd4;
    localparam logic [3:0] S_MUL_HI   = 4'd5;
    localparam logic [3:0] S_SUM      = 4'd6;
    localparam logic [3:0] S_DECIDE   = 4'd7;
    localparam logic [3:0] S_WRITE    = 4'd8;
    localparam logic [3:0] S_MUL_K    = 4'd9;
    localparam logic [3:0] S_DIV_INIT = 4'd10;
    localparam logic [3:0] S_DIV      = 4'd11;
    localparam logic [3:0] S_DIV_END  = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
                state_next = S_ELAPSED;
            S_ELAPSED:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!status.is_query)
                    state_next = S_WRITE;
                else if (!status.was_valid || status.has_token)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_DONE;
                end
                else if (status.rate_zero)
                begin
                    cmd.res_hour = 1'b1;
                    state_next   = S_DONE;
                end
                else
                    state_next = S_MUL_K;
            end
            S_WRITE:
            begin
                cmd.write_back = 1'b1;
                state_next     = S_DONE;
            end
            S_MUL_K:
            begin
                cmd.mul_k  = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_DIV_END;
            end
            S_DIV_END:
            begin
                cmd.div_end = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

endmodule

// ===== src/tbrl_dp.sv =====
// ============================================================================
// tbrl_dp
// Bucket table, shared multiplier, refill adder, restoring divider, result
// and output registers.
// ============================================================================
module tbrl_dp #(
    parameter int ACCOUNT_SLOTS = tbrl_pkg::DEF_ACCOUNT_SLOTS,
    parameter int NUM_CHANNELS  = tbrl_pkg::DEF_NUM_CHANNELS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tbrl_pkg::req_t         req_data,
    input  tbrl_pkg::cfg_t         cfg,
    input  tbrl_pkg::ctrl_cmd_t    cmd,
    output tbrl_pkg::ctrl_status_t status,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output tbrl_pkg::rsp_t         rsp_data
);
    import tbrl_pkg::*;

    localparam int TABLE_SIZE = ACCOUNT_SLOTS * NUM_CHANNELS;
    localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int SLOT_W     = (ACCOUNT_SLOTS > 1) ? $clog2(ACCOUNT_SLOTS) : 1;
    localparam int PROD_W     = 2 * RATE_W;
    localparam int LO_W       = TIME_W - 32;
    localparam int HI_ELAP_W  = TIME_W - 32;
    localparam int LOSH       = 32 - FRAC_W;
    localparam int LOPART_W   = PROD_W - LOSH;
    localparam int SUM_W      = LOPART_W + 1;
    localparam int NEED_W     = FRAC_W + 1;
    localparam int NEED_SH    = 13;
    localparam int QUO_W      = 23;
    localparam int NUM_W      = 43;
    localparam int CNT_W      = $clog2(QUO_W);

    // ---------------- index reduction tables
    logic [SLOT_W-1:0] slot_map [SLOT_IN_N];
    logic [CHAN_W-1:0] chan_map [CHAN_MAX];

    for (genvar i = 0; i < SLOT_IN_N; i++)
    begin : g_slot
        assign slot_map[i] = SLOT_W'(i % ACCOUNT_SLOTS);
    end
    for (genvar i = 0; i < CHAN_MAX; i++)
    begin : g_chan
        assign chan_map[i] = CHAN_W'(i % NUM_CHANNELS);
    end

    // ---------------- request registers
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [CHAN_W-1:0] ch_reg;
    logic              op_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SLOT_W-1:0] slot_red;
    logic [CHAN_W-1:0] ch_red;

    assign slot_red = slot_map[req_data.account_slot];
    assign ch_red   = chan_map[req_data.chan_index];
    assign idx_next = ADDR_W'(ADDR_W'(slot_red) * ADDR_W'(NUM_CHANNELS)) + ADDR_W'(ch_red);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            idx_reg <= idx_next;
            ch_reg  <= ch_red;
            op_reg  <= req_data.opcode;
            now_reg <= req_data.now_us;
        end
    end

    // ---------------- bucket table
    logic              valid_mem [TABLE_SIZE];
    logic [TOK_W-1:0]  tok_mem   [TABLE_SIZE];
    logic [TIME_W-1:0] time_mem  [TABLE_SIZE];
    logic              rd_valid_reg;
    logic [TOK_W-1:0]  rd_tok_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [TOK_W-1:0]  wr_tok;
    logic [TIME_W-1:0] wr_time;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear_step)
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
    end

    assign status.clear_last = (clr_addr_reg == ADDR_W'(TABLE_SIZE - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            valid_mem[clr_addr_reg] <= 1'b0;
        else if (cmd.write_back)
            valid_mem[idx_reg] <= 1'b1;
        rd_valid_reg <= valid_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_back)
        begin
            tok_mem[idx_reg]  <= wr_tok;
            time_mem[idx_reg] <= wr_time;
        end
        rd_tok_reg  <= tok_mem[idx_reg];
        rd_time_reg <= time_mem[idx_reg];
    end

    // ---------------- bucket state of the current request
    logic              was_valid_reg;
    logic              adv_reg;
    logic [TOK_W-1:0]  tok_cur_reg;
    logic [TIME_W-1:0] last_cur_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [TOK_W-1:0]  cap_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [TOK_W-1:0]  cap_full;

    assign cap_full = {cfg.capacity[ch_reg], FRAC_W'(0)};

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            was_valid_reg <= rd_valid_reg;
            cap_reg       <= cap_full;
            rate_reg      <= cfg.rate[ch_reg];
            if (op_reg == OP_CONSUME && !rd_valid_reg)
            begin
                // new bucket starts full, stamped now
                tok_cur_reg  <= cap_full;
                last_cur_reg <= now_reg;
                adv_reg      <= 1'b0;
                elapsed_reg  <= '0;
            end
            else
            begin
                tok_cur_reg  <= rd_tok_reg;
                last_cur_reg <= rd_time_reg;
                adv_reg      <= (now_reg > rd_time_reg);
                elapsed_reg  <= now_reg - rd_time_reg;
            end
        end
    end

    // ---------------- shared multiplier
    logic [31:0]         mul_a;
    logic [RATE_W-1:0]   mul_b;
    logic [PROD_W-1:0]   prod_reg;
    logic [LOPART_W-1:0] lo_part_reg;

    always_comb
    begin
        mul_a = elapsed_reg[31:0];
        mul_b = rate_reg;
        if (cmd.mul_hi)
            mul_a = 32'(elapsed_reg[TIME_W-1:32]);
        else if (cmd.mul_k)
        begin
            mul_a = rate_reg;
            mul_b = RATE_W'(MS_SCALE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo || cmd.mul_hi || cmd.mul_k)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.mul_hi)
            lo_part_reg <= prod_reg[PROD_W-1:LOSH];
    end

    // ---------------- refill
    logic             hi_over;
    logic [SUM_W-1:0] sum_full;
    logic [TOK_W-1:0] t_reg;
    logic [TOK_W-1:0] t_next;

    assign hi_over  = |prod_reg[HI_ELAP_W+31:CAP_W];
    assign sum_full = SUM_W'(tok_cur_reg) + SUM_W'({prod_reg[CAP_W-1:0], FRAC_W'(0)})
                    + SUM_W'(lo_part_reg);

    always_comb
    begin
        if (!adv_reg)
            t_next = tok_cur_reg;
        else if (hi_over)
            t_next = cap_reg;
        else if (sum_full > SUM_W'(cap_reg))
            t_next = cap_reg;
        else
            t_next = sum_full[TOK_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
            t_reg <= t_next;
    end

    assign status.is_query  = (op_reg == OP_QUERY);
    assign status.was_valid = was_valid_reg;
    assign status.has_token = (t_reg >= ONE_TOKEN);
    assign status.rate_zero = (rate_reg == '0);

    assign wr_tok  = status.has_token ? (t_reg - ONE_TOKEN) : t_reg;
    assign wr_time = adv_reg ? now_reg : last_cur_reg;

    // ---------------- live bucket count
    logic [LIVE_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.write_back && !was_valid_reg && count_reg != LIVE_MAX)
            count_reg <= count_reg + LIVE_W'(1);
    end

    // ---------------- restoring divider, one quotient bit per cycle
    logic [NEED_W-1:0] need;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  den_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  numlow_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [NUM_W:0]    rem_shift;
    logic              quo_bit;

    assign need      = NEED_W'(ONE_TOKEN - t_reg);
    assign num       = NUM_W'({need, NEED_SH'(0)}) + prod_reg[NUM_W-1:0];
    assign rem_shift = {rem_reg, numlow_reg[QUO_W-1]};
    assign quo_bit   = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            den_reg     <= {prod_reg[NUM_W-2:0], 1'b0};
            rem_reg     <= NUM_W'(num[NUM_W-1:QUO_W]);
            numlow_reg  <= num[QUO_W-1:0];
            quo_reg     <= '0;
            div_cnt_reg <= CNT_W'(QUO_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (quo_bit)
                rem_reg <= NUM_W'(rem_shift - {1'b0, den_reg});
            else
                rem_reg <= rem_shift[NUM_W-1:0];
            numlow_reg  <= {numlow_reg[QUO_W-2:0], 1'b0};
            quo_reg     <= {quo_reg[QUO_W-2:0], quo_bit};
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
    end

    assign status.div_last = (div_cnt_reg == '0);

    // ---------------- result and output register
    logic               res_allowed_reg;
    logic [RETRY_W-1:0] res_retry_reg;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_back)
        begin
            res_allowed_reg <= status.has_token;
            res_retry_reg   <= '0;
        end
        else if (cmd.res_zero)
        begin
            res_allowed_reg <= 1'b0;
            res_retry_reg   <= '0;
        end
        else if (cmd.res_hour)
        begin
            res_allowed_reg <= 1'b0;
            res_retry_reg   <= HOUR_MS;
        end
        else if (cmd.div_end)
        begin
            res_allowed_reg <= 1'b0;
            res_retry_reg   <= (quo_reg > QUO_W'(HOUR_MS)) ? HOUR_MS
                                                           : quo_reg[RETRY_W-1:0];
        end
    end

    assign status.out_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid_next  = cmd.load_out || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_data_reg.allowed      <= res_allowed_reg;
            rsp_data_reg.retry_ms     <= res_retry_reg;
            rsp_data_reg.live_buckets <= count_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ---------------- checks
    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write_back && !was_valid_reg && count_reg != LIVE_MAX)
        |=> (count_reg == $past(count_reg) + LIVE_W'(1)))
        else $error("live count missed a new bucket");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result loaded over a stalled response");

    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_data_reg.retry_ms <= HOUR_MS
                           && !(rsp_data_reg.allowed && rsp_data_reg.retry_ms != '0)))
        else $error("response retry out of range");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the token bucket rate limiter. A short directed
// table with settings changes runs first, then random phases on hot account
// slots. Responses must match typed table values or the bucket-table model kept here.
// ============================================================================
module tb_top;
    import tbrl_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 6;
    localparam int PHASE_REQS  = 275;
    localparam int HOT_SLOTS   = 6;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_PRINTS  = 40;
    localparam int BUCKETS     = DEF_ACCOUNT_SLOTS * DEF_NUM_CHANNELS;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    // one line of the directed table: a request or a register write
    typedef struct {
        row_kind_e                 kind;
        req_t                      req;
        bit                        typed;
        rsp_t                      want;
        logic [CFG_IDX_W-1:0]      reg_idx;
        logic [CFG_DATA_W-1:0]     reg_val;
    } stim_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    req_t                  req_data  = '0;
    logic                  rsp_stall = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  req_stall;
    logic                  rsp_valid;
    rsp_t                  rsp_data;

    // model copy of the channel settings
    logic [CAP_W-1:0]  cap_setting  [CHAN_MAX];
    logic [RATE_W-1:0] rate_setting [CHAN_MAX];

    // model copy of the bucket table
    bit                bucket_live  [BUCKETS];
    logic [TOK_W-1:0]  bucket_level [BUCKETS];
    logic [TIME_W-1:0] bucket_stamp [BUCKETS];
    int unsigned       buckets_made;

    rsp_t              verdicts_due [$];   // expected responses, oldest first
    stim_row_t         stim_rows [$];
    int unsigned       n_mismatch = 0;

    bit                calm    = 1'b0;     // no idling on either side
    bit                hold_go = 1'b0;     // starts the long receiver hold-off
    bit                hold_on = 1'b0;
    logic [TIME_W-1:0] wall_us = '0;
    logic [SLOT_IN_W-1:0] hot_slot [HOT_SLOTS];

    token_bucket_rate_limiter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // bucket model
    // ------------------------------------------------------------------------

    // level after refilling from stamp to now; moved is set when time advanced
    function automatic logic [TOK_W-1:0] refill_level(input logic [TOK_W-1:0] level,
                                                      input logic [TIME_W-1:0] stamp,
                                                      input logic [TIME_W-1:0] now,
                                                      input int ch, output bit moved);
        logic [63:0] cap_fx, rate, elapsed, hi_prod, lo_part, total;
        cap_fx = 64'(cap_setting[ch]) << FRAC_W;
        rate   = 64'(rate_setting[ch]);
        moved  = 1'b0;
        if (now <= stamp)
            return level;
        moved   = 1'b1;
        elapsed = 64'(now - stamp);
        // once the upper half of elapsed time alone gives 2**CAP_W tokens, any bucket is full
        hi_prod = (elapsed >> RATE_W) * rate;
        if (hi_prod >= (64'd1 << CAP_W))
            return cap_fx[TOK_W-1:0];
        // 32.32 product of elapsed time and the 0.32 rate cut down to 32.20
        lo_part = ((elapsed & 64'hFFFF_FFFF) * rate) >> (RATE_W - FRAC_W);
        total   = 64'(level) + (hi_prod << FRAC_W) + lo_part;
        if (total > cap_fx)
            total = cap_fx;
        return total[TOK_W-1:0];
    endfunction

    // expected response of one request, updating the model table
    function automatic rsp_t rate_verdict(input req_t r);
        rsp_t             v;
        int               ch, idx;
        bit               moved;
        logic [TOK_W-1:0] level;
        logic [63:0]      rate, need, num, den, ms;
        v   = '0;
        ch  = int'(r.chan_index) % DEF_NUM_CHANNELS;
        idx = (int'(r.account_slot) % DEF_ACCOUNT_SLOTS) * DEF_NUM_CHANNELS + ch;
        if (r.opcode == OP_CONSUME)
        begin
            // a missing bucket starts full at the request time
            if (!bucket_live[idx])
            begin
                bucket_live[idx]  = 1'b1;
                bucket_level[idx] = TOK_W'(cap_setting[ch]) << FRAC_W;
                bucket_stamp[idx] = r.now_us;
                buckets_made++;
            end
            level = refill_level(bucket_level[idx], bucket_stamp[idx], r.now_us, ch, moved);
            if (moved)
            begin
                bucket_level[idx] = level;
                bucket_stamp[idx] = r.now_us;
            end
            if (level >= ONE_TOKEN)
            begin
                bucket_level[idx] = level - ONE_TOKEN;
                v.allowed = 1'b1;
            end
        end
        else if (bucket_live[idx])
        begin
            // query refills a copy only
            level = refill_level(bucket_level[idx], bucket_stamp[idx], r.now_us, ch, moved);
            if (level < ONE_TOKEN)
            begin
                rate = 64'(rate_setting[ch]);
                if (rate == 0)
                    v.retry_ms = HOUR_MS;
                else
                begin
                    // ms = need / rate / 1000 rounded half up, all in integers
                    need = 64'(ONE_TOKEN - level);
                    den  = rate * (2 * MS_SCALE);
                    num  = (need << (RATE_W - FRAC_W + 1)) + rate * MS_SCALE;
                    ms   = num / den;
                    v.retry_ms = (ms > 64'(HOUR_MS)) ? HOUR_MS : ms[RETRY_W-1:0];
                end
            end
        end
        v.live_buckets = (buckets_made > LIVE_MAX) ? LIVE_MAX : buckets_made[LIVE_W-1:0];
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS)
            $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic logic [CFG_IDX_W-1:0] reg_index(input int ch, input logic sel);
        return (CFG_IDX_W'(ch) << 1) | CFG_IDX_W'(sel);
    endfunction

    function automatic void add_req(input logic op, input int slot, input int ch,
                                    input logic [TIME_W-1:0] now, input bit typed,
                                    input rsp_t want);
        stim_row_t row;
        row.kind             = ROW_REQ;
        row.req.opcode       = op;
        row.req.account_slot = SLOT_IN_W'(slot);
        row.req.chan_index   = CHAN_W'(ch);
        row.req.now_us       = now;
        row.typed            = typed;
        row.want             = want;
        row.reg_idx          = '0;
        row.reg_val          = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input int ch, input logic sel,
                                    input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.kind    = ROW_CFG;
        row.req     = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        row.reg_idx = reg_index(ch, sel);
        row.reg_val = val;
        stim_rows.push_back(row);
    endfunction

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return $urandom_range(1, 3);
        if (k < 92)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // next random request: mostly hot slots, time held or moved forward with some jumps
    function automatic req_t next_request();
        req_t r;
        int   k;
        r.opcode = ($urandom_range(0, 1) == 0) ? OP_CONSUME : OP_QUERY;
        if ($urandom_range(0, 99) < 70)
            r.account_slot = hot_slot[$urandom_range(0, HOT_SLOTS - 1)];
        else
            r.account_slot = SLOT_IN_W'($urandom_range(0, SLOT_IN_N - 1));
        r.chan_index = CHAN_W'($urandom_range(0, CHAN_MAX - 1));
        k = $urandom_range(0, 99);
        if (k >= 97)
            wall_us = TIME_MAX;
        else if (k >= 95)
            wall_us = '0;
        else if (k >= 90)
            wall_us -= TIME_W'($urandom_range(1, 5000));      // clock goes back
        else if (k >= 85)
            wall_us = {16'($urandom), 32'($urandom)};
        else if (k >= 70)
            wall_us += TIME_W'($urandom_range(1, 3_000_000));
        else if (k >= 35)
            wall_us += TIME_W'($urandom_range(1, 3000));
        r.now_us = wall_us;
        return r;
    endfunction

    // offer one request and wait for it to be taken
    task automatic offer(input req_t r, input bit typed, input rsp_t want);
        rsp_t predicted;
        if (cfg_wr_en)
            cfg_wr_en <= 1'b0;
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = rate_verdict(r);
        verdicts_due.push_back(typed ? want : predicted);
    endtask

    task automatic pause_sender();
        int n;
        if (!calm && $urandom_range(0, 99) >= 45)
        begin
            n = idle_len();
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // wait until every request has answered, so the block is idle
    task automatic drain();
        req_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx[0] == CFG_SEL_CAPACITY)
            cap_setting[idx[CFG_IDX_W-1:1]] = val[CAP_W-1:0];
        else
            rate_setting[idx[CFG_IDX_W-1:1]] = val[RATE_W-1:0];
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] word;
        logic [CAP_W-1:0]      cap_pick;
        logic [RATE_W-1:0]     rate_pick;
        int                    k;
        for (int ch = 0; ch < CHAN_MAX; ch++)
        begin
            cap_setting[ch]  = CAP_RESET;
            rate_setting[ch] = RATE_RESET;
        end
        buckets_made = 0;

        // directed table, reset settings first
        add_req(OP_QUERY,   0, 0, 100, 1'b1, rsp_t'{1'b0, 22'd0, 11'd0}); // unknown bucket
        add_req(OP_CONSUME, 0, 0, 100, 1'b1, rsp_t'{1'b1, 22'd0, 11'd1}); // created full
        add_req(OP_CONSUME, 1, 1, 0,   1'b1, rsp_t'{1'b1, 22'd0, 11'd2});
        add_cfg(0, CFG_SEL_CAPACITY, 1);
        add_req(OP_CONSUME, 2, 0, 1000, 1'b1, rsp_t'{1'b1, 22'd0, 11'd3}); // last token
        add_req(OP_CONSUME, 2, 0, 1000, 1'b1, rsp_t'{1'b0, 22'd0, 11'd3}); // empty
        add_req(OP_QUERY,   2, 0, 1000, 1'b0, '0);
        add_req(OP_QUERY,   2, 0, 500,  1'b0, '0);                          // earlier time
        add_req(OP_QUERY,   2, 0, 501000, 1'b0, '0);                        // partial refill
        add_cfg(0, CFG_SEL_RATE, 0);
        add_req(OP_QUERY,   2, 0, 2000000, 1'b1, rsp_t'{1'b0, HOUR_MS, 11'd3}); // zero rate
        add_cfg(0, CFG_SEL_RATE, 32'hFFFF_FFFF);
        add_req(OP_QUERY,   2, 0, 1001, 1'b0, '0);
        add_req(OP_CONSUME, 2, 0, 1002, 1'b0, '0);
        add_cfg(1, CFG_SEL_CAPACITY, 0);
        add_req(OP_CONSUME, 3, 1, 5, 1'b1, rsp_t'{1'b0, 22'd0, 11'd4});     // zero capacity
        add_req(OP_QUERY,   3, 1, TIME_MAX, 1'b0, '0);
        add_cfg(1, CFG_SEL_RATE, 1);
        add_req(OP_QUERY,   3, 1, TIME_MAX, 1'b1, rsp_t'{1'b0, HOUR_MS, 11'd4}); // wait clamps
        add_cfg(2, CFG_SEL_CAPACITY, 4095);
        add_req(OP_CONSUME, 255, 2, TIME_MAX, 1'b1, rsp_t'{1'b1, 22'd0, 11'd5});
        add_req(OP_QUERY,   255, 2, TIME_MAX, 1'b1, rsp_t'{1'b0, 22'd0, 11'd5});
        // lowered capacity leaves the level alone until time moves on
        add_cfg(2, CFG_SEL_CAPACITY, 1);
        add_req(OP_CONSUME, 255, 2, TIME_MAX, 1'b1, rsp_t'{1'b1, 22'd0, 11'd5});
        add_req(OP_CONSUME, 255, 2, 0, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                drain();
                cfg_write(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            end
            else
            begin
                offer(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
                pause_sender();
            end
        end

        // random phases, each with fresh settings on every register
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            calm <= (p == 0);
            for (int ch = 0; ch < CHAN_MAX; ch++)
            begin
                k = $urandom_range(0, 9);
                case (k)
                    0:          cap_pick = '0;
                    1:          cap_pick = '1;
                    2:          cap_pick = 1;
                    3, 4, 5, 6: cap_pick = CAP_W'($urandom_range(1, 8));
                    default:    cap_pick = CAP_W'($urandom_range(2, 64));
                endcase
                // upper data bits are sometimes junk, only the low field counts
                word = $urandom;
                if ($urandom_range(0, 3) != 0)
                    word = '0;
                word[CAP_W-1:0] = cap_pick;
                cfg_write(reg_index(ch, CFG_SEL_CAPACITY), word);

                k = $urandom_range(0, 9);
                case (k)
                    0:       rate_pick = '0;
                    1:       rate_pick = '1;
                    2:       rate_pick = 1;
                    3, 4:    rate_pick = RATE_RESET;
                    5, 6:    rate_pick = $urandom_range(1, 50000);
                    7:       rate_pick = $urandom;
                    default: rate_pick = $urandom_range(50000, 5_000_000);
                endcase
                cfg_write(reg_index(ch, CFG_SEL_RATE), rate_pick);
            end
            foreach (hot_slot[h])
                hot_slot[h] = SLOT_IN_W'($urandom_range(0, SLOT_IN_N - 1));

            for (int i = 0; i < PHASE_REQS; i++)
            begin
                offer(next_request(), 1'b0, '0);
                // receiver backs off for a long stretch while requests keep coming
                if (p == 2 && i == 40)
                    hold_go <= 1'b1;
                pause_sender();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_mismatch == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // response side: check against the oldest expectation, random stalls
    // ------------------------------------------------------------------------
    initial
    begin : rsp_side
        rsp_t        want;
        int unsigned stall_left;
        bit          stall_next;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch("unexpected response", rsp_data, 0);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (rsp_data.allowed !== want.allowed)
                        report_mismatch("allowed", rsp_data.allowed, want.allowed);
                    if (rsp_data.retry_ms !== want.retry_ms)
                        report_mismatch("retry_ms", rsp_data.retry_ms, want.retry_ms);
                    if (rsp_data.live_buckets !== want.live_buckets)
                        report_mismatch("live_buckets", rsp_data.live_buckets,
                                        want.live_buckets);
                end
            end
            if (hold_on)
                stall_next = 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                stall_left = idle_len() - 1;
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            rsp_stall <= stall_next;
        end
    end

    // long hold-off, counted here so the block backs up into its request side
    initial
    begin : hold_off
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // run limit
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
src/tbrl_pkg.sv
src/tbrl_cfg.sv
src/tbrl_ctrl.sv
src/tbrl_dp.sv
src/token_bucket_rate_limiter.sv
tb/sv/tb_top.sv
